[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[hw/rtl/essr_pkg.sv]
package essr_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic [11:0] PULSE_MIN = 12'd1000;
  localparam logic [11:0] PULSE_MAX = 12'd2000;
  localparam logic [15:0] PERIOD_US = 16'd20000;

  // pulse (11 bits) * full scale (16 bits) < 2^27
  localparam int DUTY_NUM_W = 27;
  // floor(x/20000) = floor((x >> 5) / 625); x >> 5 < 2^22, and
  // ceil(2^32/625) * 625 - 2^32 = 204 with 204 * 2^22 < 2^32, so the
  // reciprocal product shifted down by 32 is exact over that range
  localparam int          DUTY_SHIFT  = 5;
  localparam int          DUTY_RCP_SH = 32;
  localparam logic [22:0] DUTY_RCP    = 23'd6871948;

  localparam logic [15:0] DUR_RESET = 16'd2000;
  localparam logic [4:0]  RES_RESET = 5'd16;
  localparam logic [4:0]  RES_MAX   = 5'd16;

  localparam logic [0:0] CFG_DUTY_RES = 1'd0;
  localparam logic [0:0] CFG_RAMP_DUR = 1'd1;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;
  localparam logic [1:0] MODE_ESTOP = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] target_pulse;
    logic        manual;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [11:0] pulse_width;
    logic [15:0] duty;
    logic        out_of_range;
    logic        ramp_busy;
    logic        running;
    logic        stopped;
    logic        emergency;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INC,
    OP_DIVP,
    OP_DIV_STEP,
    OP_MUL_PP,
    OP_MUL_S,
    OP_MUL_D,
    OP_PULSE,
    OP_RAMP_END,
    OP_CMD,
    OP_CHECK,
    OP_MUL_FULL,
    OP_DUTY,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_TICK,
    C_RAMP_OFF,
    C_RAMP_DONE,
    C_DIV_MORE,
    C_OOR,
    C_NOT_ESTOP
  } cond_t;

  localparam int UA_W = 5;
  typedef logic [UA_W-1:0] uaddr_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    uaddr_t target;
    logic   last;
  } ucode_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } seq_ctl_t;

  typedef struct packed {
    logic not_tick;
    logic ramp_off;
    logic ramp_done;
    logic div_more;
    logic oor;
    logic not_estop;
  } dp_stat_t;

  localparam uaddr_t UA_DECODE   = 5'd0;
  localparam uaddr_t UA_RAMP_CHK = 5'd1;
  localparam uaddr_t UA_INC      = 5'd2;
  localparam uaddr_t UA_END_CHK  = 5'd3;
  localparam uaddr_t UA_DIVP     = 5'd4;
  localparam uaddr_t UA_DIVP_LP  = 5'd5;
  localparam uaddr_t UA_MUL_PP   = 5'd6;
  localparam uaddr_t UA_MUL_S    = 5'd7;
  localparam uaddr_t UA_MUL_D    = 5'd8;
  localparam uaddr_t UA_PULSE    = 5'd9;
  localparam uaddr_t UA_RAMP_END = 5'd10;
  localparam uaddr_t UA_CMD      = 5'd11;
  localparam uaddr_t UA_CHECK    = 5'd12;
  localparam uaddr_t UA_MUL_FULL = 5'd13;
  localparam uaddr_t UA_DUTY     = 5'd14;
  localparam uaddr_t UA_FINISH   = 5'd15;

  function automatic ucode_t uw(dp_op_t op, cond_t cond, uaddr_t target, logic last);
    ucode_t w;
    w.op     = op;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // Control store: one word per step, conditional jump to target else fall through
  function automatic ucode_t ucode_rom(uaddr_t a);
    ucode_t w;
    unique case (a)
      UA_DECODE:   w = uw(OP_NOP,      C_NOT_TICK,  UA_CMD,      1'b0);
      UA_RAMP_CHK: w = uw(OP_NOP,      C_RAMP_OFF,  UA_FINISH,   1'b0);
      UA_INC:      w = uw(OP_INC,      C_NEVER,     UA_DECODE,   1'b0);
      UA_END_CHK:  w = uw(OP_NOP,      C_RAMP_DONE, UA_RAMP_END, 1'b0);
      UA_DIVP:     w = uw(OP_DIVP,     C_NEVER,     UA_DECODE,   1'b0);
      UA_DIVP_LP:  w = uw(OP_DIV_STEP, C_DIV_MORE,  UA_DIVP_LP,  1'b0);
      UA_MUL_PP:   w = uw(OP_MUL_PP,   C_NEVER,     UA_DECODE,   1'b0);
      UA_MUL_S:    w = uw(OP_MUL_S,    C_NEVER,     UA_DECODE,   1'b0);
      UA_MUL_D:    w = uw(OP_MUL_D,    C_NEVER,     UA_DECODE,   1'b0);
      UA_PULSE:    w = uw(OP_PULSE,    C_ALWAYS,    UA_CHECK,    1'b0);
      UA_RAMP_END: w = uw(OP_RAMP_END, C_ALWAYS,    UA_CHECK,    1'b0);
      UA_CMD:      w = uw(OP_CMD,      C_NOT_ESTOP, UA_FINISH,   1'b0);
      UA_CHECK:    w = uw(OP_CHECK,    C_OOR,       UA_FINISH,   1'b0);
      UA_MUL_FULL: w = uw(OP_MUL_FULL, C_NEVER,     UA_DECODE,   1'b0);
      UA_DUTY:     w = uw(OP_DUTY,     C_NEVER,     UA_DECODE,   1'b0);
      UA_FINISH:   w = uw(OP_FINISH,   C_NEVER,     UA_DECODE,   1'b1);
      default:     w = uw(OP_FINISH,   C_NEVER,     UA_DECODE,   1'b1);
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/esc_smoothstep_ramp_unit.sv]
// Smoothstep pulse ramp for a motor-speed controller. Each transfer on the input
// channel is a 1 ms tick, a start ramp, a stop ramp or an emergency stop, and
// yields exactly one result with the requested pulse, the PWM duty count
// floor(pulse*(2^res-1)/20000) and the running/stopped/emergency flags.
// Pulses outside 1000..2000 us are flagged and not written. One item is worked
// at a time by a small microprogram driving one shared multiplier, a bit-serial
// restoring divider for the ramp progress and a reciprocal multiply for the
// duty scaling. A tick inside a ramp runs FRAC_BITS divider steps plus 13 other
// steps before its result is loaded, and an out-of-range pulse skips the duty
// steps; a tick that ends a ramp loads the goal pulse, an emergency stop the
// minimum pulse, and start, stop and idle ticks go straight to the result.
// A new item is taken the cycle after the previous result is loaded into the
// output register, even if that result has not yet been taken; a result still
// waiting there holds the next item at its last step. Configuration is written
// through cfg_we/cfg_index/cfg_wdata (index 0: duty resolution bits, index 1:
// ramp length in ticks); the user must write it only while no item is in
// flight, since the block itself does not enforce this.
module esc_smoothstep_ramp_unit #(
  parameter int FRAC_BITS = essr_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  essr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output essr_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import essr_pkg::*;

  seq_ctl_t ctl;
  dp_stat_t stat;

  essr_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .ctl       (ctl)
  );

  essr_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/essr_div.sv]
module essr_div #(
  parameter int QW = essr_pkg::FRAC_BITS_DEF,
  parameter int CW = $clog2(QW + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          step,
  input  logic [15:0]   rem_init,
  input  logic [15:0]   divisor,
  input  logic [CW-1:0] count,
  output logic [QW-1:0] quo,
  output logic          more
);

  logic [15:0]   rem_r, rem_nxt;
  logic [15:0]   div_r;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [16:0]   trial;
  logic          ge;

  // restoring fraction division, one quotient bit per step; remainder always below divisor
  always_comb begin
    trial   = {rem_r, 1'b0};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? 16'(trial - {1'b0, div_r}) : trial[15:0];
    quo_nxt = {quo_r[QW-2:0], ge};
    cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= count;
    end else if (step) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      div_r <= divisor;
      quo_r <= '0;
    end else if (step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo  = quo_r;
  assign more = cnt_r != CW'(1);

endmodule

[hw/rtl/essr_dpath.sv]
`include "assert_macros.svh"

module essr_dpath #(
  parameter int FRAC_BITS = essr_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  essr_pkg::seq_ctl_t  ctl,
  input  essr_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output essr_pkg::dp_stat_t  stat,
  output essr_pkg::out_item_t out_data
);
  import essr_pkg::*;

  localparam int OW   = (FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16;
  localparam int PW   = 2 * OW;
  localparam int CW   = $clog2(FRAC_BITS + 1);
  localparam int DY_W = DUTY_NUM_W - DUTY_SHIFT;
  localparam int DP_W = DY_W + $bits(DUTY_RCP);

  // configuration
  logic [4:0]  res_r;
  logic [15:0] dur_r;

  // ramp state
  logic [15:0] elapsed_r;
  logic [11:0] start_r, goal_r;
  logic        ramp_on_r, startup_r, run_r, stop_r, estop_r;

  // per-item work registers
  in_item_t           item_r;
  logic [11:0]        pulse_r;
  logic [FRAC_BITS-1:0] p_r;
  logic [PW-1:0]      prod_r;
  logic               req_r, wv_r, oor_r;
  logic [15:0]        duty_r;
  out_item_t          out_r;

  logic [OW-1:0]        mul_a, mul_b;
  logic [PW-1:0]        mul_p;
  logic [FRAC_BITS+1:0] k3, w3;
  logic [FRAC_BITS-1:0] hi_f;
  logic [11:0]          diff, delta;
  logic                 up;
  logic [4:0]           res_eff;
  logic [16:0]          full;
  logic                 oor_now;
  logic [DP_W-1:0]      duty_p;

  logic [FRAC_BITS-1:0] quo;
  logic                 div_more;

  always_comb begin
    hi_f    = prod_r[2*FRAC_BITS-1:FRAC_BITS];
    k3      = (FRAC_BITS + 2)'(3) << FRAC_BITS;
    w3      = k3 - {1'b0, p_r, 1'b0};
    up      = goal_r >= start_r;
    diff    = up ? goal_r - start_r : start_r - goal_r;
    delta   = prod_r[FRAC_BITS+11:FRAC_BITS];
    res_eff = (res_r > RES_MAX) ? RES_MAX : res_r;
    full    = (17'd1 << res_eff) - 17'd1;
    oor_now = (pulse_r < PULSE_MIN) || (pulse_r > PULSE_MAX);
    // divide by 20000 as a shift by 5 and a reciprocal multiply for 625
    duty_p  = DP_W'(prod_r[DUTY_NUM_W-1:DUTY_SHIFT]) * DP_W'(DUTY_RCP);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.op)
      OP_MUL_PP: begin
        mul_a = OW'(quo[FRAC_BITS-1:0]);
        mul_b = OW'(quo[FRAC_BITS-1:0]);
      end
      OP_MUL_S: begin
        mul_a = OW'(hi_f);
        mul_b = OW'(w3);
      end
      OP_MUL_D: begin
        mul_a = OW'(diff);
        mul_b = OW'(hi_f);
      end
      OP_MUL_FULL: begin
        mul_a = OW'(pulse_r);
        mul_b = OW'(full[15:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  essr_div #(
    .QW (FRAC_BITS),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.op == OP_DIVP),
    .step     (ctl.op == OP_DIV_STEP),
    .rem_init (elapsed_r),
    .divisor  (dur_r),
    .count    (CW'(FRAC_BITS)),
    .quo      (quo),
    .more     (div_more)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= RES_RESET;
      dur_r <= DUR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DUTY_RES: res_r <= cfg_wdata[4:0];
        CFG_RAMP_DUR: dur_r <= cfg_wdata;
        default:      dur_r <= dur_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      start_r   <= PULSE_MIN;
      goal_r    <= PULSE_MIN;
      ramp_on_r <= 1'b0;
      startup_r <= 1'b0;
      run_r     <= 1'b0;
      stop_r    <= 1'b1;
      estop_r   <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_INC: begin
          if (elapsed_r != 16'hFFFF) elapsed_r <= elapsed_r + 16'd1;
        end
        OP_PULSE: begin
          // start ramp of a non-manual item tracks the live target after this point is taken
          if (startup_r && !item_r.manual) goal_r <= item_r.target_pulse;
        end
        OP_RAMP_END: begin
          ramp_on_r <= 1'b0;
          run_r     <= startup_r;
          stop_r    <= !startup_r;
        end
        OP_CMD: begin
          if (item_r.mode == MODE_ESTOP) begin
            ramp_on_r <= 1'b0;
            estop_r   <= 1'b1;
            run_r     <= 1'b0;
            stop_r    <= 1'b1;
          end else if (!ramp_on_r) begin
            elapsed_r <= '0;
            ramp_on_r <= 1'b1;
            if (item_r.mode == MODE_START) begin
              start_r   <= PULSE_MIN;
              goal_r    <= item_r.target_pulse;
              startup_r <= 1'b1;
            end else begin
              start_r   <= item_r.target_pulse;
              goal_r    <= PULSE_MIN;
              startup_r <= 1'b0;
            end
          end
        end
        default: begin
          elapsed_r <= elapsed_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= 1'b0;
      wv_r  <= 1'b0;
      oor_r <= 1'b0;
    end else if (ctl.load) begin
      req_r <= 1'b0;
      wv_r  <= 1'b0;
      oor_r <= 1'b0;
    end else if (ctl.op == OP_CHECK) begin
      req_r <= 1'b1;
      oor_r <= oor_now;
    end else if (ctl.op == OP_DUTY) begin
      wv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
      duty_r <= '0;
    end
    unique case (ctl.op)
      OP_MUL_PP: begin
        p_r    <= quo[FRAC_BITS-1:0];
        prod_r <= mul_p;
      end
      OP_MUL_S, OP_MUL_D, OP_MUL_FULL: prod_r <= mul_p;
      OP_PULSE:    pulse_r <= up ? start_r + delta : start_r - delta;
      OP_RAMP_END: pulse_r <= goal_r;
      OP_CMD:      pulse_r <= PULSE_MIN;
      OP_DUTY:     duty_r  <= 16'(duty_p[DP_W-1:DUTY_RCP_SH]);
      OP_FINISH: begin
        out_r.write_valid  <= wv_r;
        out_r.pulse_width  <= req_r ? pulse_r : 12'd0;
        out_r.duty         <= duty_r;
        out_r.out_of_range <= oor_r;
        out_r.ramp_busy    <= ramp_on_r;
        out_r.running      <= run_r;
        out_r.stopped      <= stop_r;
        out_r.emergency    <= estop_r;
      end
      default: begin
        p_r <= p_r;
      end
    endcase
  end

  always_comb begin
    stat.not_tick  = item_r.mode != MODE_TICK;
    stat.ramp_off  = !ramp_on_r;
    stat.ramp_done = elapsed_r >= dur_r;
    stat.div_more  = div_more;
    stat.oor       = oor_now;
    stat.not_estop = item_r.mode != MODE_ESTOP;
  end

  assign out_data = out_r;

  `ASSERT_CLK(a_run_stop_excl, clk, rst_n, $onehot({run_r, stop_r}), "run and stop flags both or neither set")
  `ASSERT_NEVER(a_wr_and_oor, clk, rst_n, wv_r && oor_r, "duty written for an out-of-range pulse")
  `ASSERT_CLK(a_estop_sticky, clk, rst_n, $past(estop_r) |-> estop_r, "emergency flag cleared outside reset")

endmodule

[hw/rtl/essr_seq.sv]
`include "assert_macros.svh"

module essr_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  essr_pkg::dp_stat_t stat,
  output essr_pkg::seq_ctl_t ctl
);
  import essr_pkg::*;

  uaddr_t pc_r, pc_nxt;
  logic   busy_r, busy_nxt;
  logic   out_valid_r, out_valid_nxt;
  ucode_t word;
  logic   take;
  logic   stall;
  logic   step_en;
  logic   accept;

  always_comb begin
    word = ucode_rom(pc_r);
    unique case (word.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NOT_TICK:  take = stat.not_tick;
      C_RAMP_OFF:  take = stat.ramp_off;
      C_RAMP_DONE: take = stat.ramp_done;
      C_DIV_MORE:  take = stat.div_more;
      C_OOR:       take = stat.oor;
      C_NOT_ESTOP: take = stat.not_estop;
      default:     take = 1'b0;
    endcase
    // result register still full and not drained this cycle
    stall   = (word.op == OP_FINISH) && out_valid_r && !out_ready;
    step_en = busy_r && !stall;
    accept  = in_valid && !busy_r;

    pc_nxt        = pc_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept) begin
      pc_nxt   = UA_DECODE;
      busy_nxt = 1'b1;
    end else if (step_en) begin
      pc_nxt = take ? word.target : pc_r + uaddr_t'(1);
      if (word.last) busy_nxt = 1'b0;
      if (word.op == OP_FINISH) out_valid_nxt = 1'b1;
    end

    ctl.load = accept;
    ctl.op   = step_en ? word.op : OP_NOP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= UA_DECODE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = !busy_r;
  assign out_valid = out_valid_r;

  `ASSERT_CLK(a_accept_starts, clk, rst_n, (in_valid && in_ready) |=> (busy_r && pc_r == UA_DECODE), "transfer did not start the program")
  `ASSERT_CLK(a_pc_in_rom, clk, rst_n, busy_r |-> (pc_r <= UA_FINISH), "step counter left the program")
  `ASSERT_CLK(a_finish_waits, clk, rst_n, (busy_r && pc_r == UA_FINISH && out_valid_r && !out_ready) |=> (busy_r && pc_r == UA_FINISH), "result overwrote an untaken result")

endmodule
